### src/bstl_pkg.sv
// Shared types and codes for the bucketed sorted table lookup block.
package bstl_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_ORDER     = 2'd3;

  localparam int unsigned IN_KEY_WIDTH = 32;
  localparam int unsigned POS_WIDTH    = 32;
  localparam int unsigned IDX_WIDTH    = 16;

  typedef struct packed {
    logic [1:0]              action;
    logic [IN_KEY_WIDTH-1:0] key;
    logic [POS_WIDTH-1:0]    text_position;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_WIDTH-1:0] entry_index;
    logic [POS_WIDTH-1:0] found_text_position;
  } out_t;

  typedef struct packed {
    logic go;
    logic lt;
    logic gt;
    logic m_zero;
  } step_t;

endpackage

### src/bucketed_sorted_table_lookup.sv
// Top level: sorted (key, text position) table with bucket index and binary search.
//
// Each beat carries one action and gives one result beat. A clear, an unused
// action or a refused load goes straight to its result. A taken load writes the
// entry and fills bucket entries from the one after the last loaded bucket (from
// bucket 0 for the first entry) up to its own, up to 2^BUCKET_BITS when the first
// entry lands in the top bucket, one at a time through the single write port of
// the bucket memory. A query goes straight to its result when the table is empty
// or the bucket lies above the last loaded one. Else it reads the bucket start,
// and the next start when the bucket lies below the last loaded one, and ends
// if that range is empty; else a binary search runs, at most ceil(log2(range + 1))
// probes (17 for a full 65536-entry range), each one registered read of the entry
// memory through the shared step unit. No new beat is taken while an item is in
// work; a finished result waits in the output register as the next beat is taken.
module bucketed_sorted_table_lookup #(
  parameter int unsigned BUCKET_BITS = 12,
  parameter int unsigned TABLE_DEPTH = 65536,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bstl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bstl_pkg::out_t out_data_o
);

  localparam int unsigned KW        = (KEY_WIDTH < bstl_pkg::IN_KEY_WIDTH) ?
                                      KEY_WIDTH : bstl_pkg::IN_KEY_WIDTH;
  localparam int unsigned KEY_SHIFT = (KEY_WIDTH > BUCKET_BITS) ?
                                      KEY_WIDTH - BUCKET_BITS : 0;
  localparam int unsigned CW        = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW        = $clog2(TABLE_DEPTH);
  localparam int unsigned BAW       = BUCKET_BITS + 1;
  localparam int unsigned NBE       = (1 << BUCKET_BITS) + 1;
  localparam int unsigned PW        = bstl_pkg::POS_WIDTH;
  localparam int unsigned EW        = KW + PW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD_LO,
    S_RD_HI,
    S_PROBE,
    S_CMP,
    S_EMIT
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 count_q;
  logic [BUCKET_BITS-1:0]        top_q;
  logic [KW-1:0]                 last_key_q;
  logic [KW-1:0]                 key_q;
  logic [BUCKET_BITS-1:0]        b_q;
  logic [CW-1:0]                 l_q;
  logic [CW-1:0]                 r_q;
  logic [CW-1:0]                 m_q;
  logic [BAW-1:0]                fill_q;
  logic [CW-1:0]                 fill_val_q;
  bstl_pkg::out_t                pend_q;
  bstl_pkg::out_t                out_q;
  logic                          out_valid_q;

  logic                          in_fire;
  logic [KW-1:0]                 key_in;
  logic [63:0]                   key_ext;
  logic [BUCKET_BITS-1:0]        b_in;
  logic                          load_full;
  logic                          load_order;
  logic                          load_ok;
  logic [BAW-1:0]                fill_start;
  logic                          emit_fire;

  logic                          ent_we;
  logic [AW-1:0]                 ent_raddr;
  logic [EW-1:0]                 ent_rdata;
  logic [KW-1:0]                 ent_key;
  logic [PW-1:0]                 ent_pos;
  logic                          bkt_we;
  logic [BAW-1:0]                bkt_raddr;
  logic [CW-1:0]                 bkt_rdata;

  logic [CW-1:0]                 mid;
  bstl_pkg::step_t               step;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign key_in      = in_data_i.key[KW-1:0];
  assign key_ext     = 64'(key_in);
  assign b_in        = BUCKET_BITS'(key_ext >> KEY_SHIFT);
  assign load_full   = (count_q >= CW'(TABLE_DEPTH));
  assign load_order  = (count_q != '0) && (key_in < last_key_q);
  assign load_ok     = !load_full && !load_order;
  assign fill_start  = (count_q == '0) ? '0 : (BAW'(top_q) + BAW'(1));
  assign emit_fire   = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  assign ent_we      = in_fire && (in_data_i.action == bstl_pkg::ACT_LOAD) && load_ok;
  assign ent_raddr   = mid[AW-1:0];
  assign ent_key     = ent_rdata[EW-1:PW];
  assign ent_pos     = ent_rdata[PW-1:0];
  assign bkt_we      = (state_q == S_FILL);

  always_comb begin
    case (state_q)
      S_IDLE:  bkt_raddr = BAW'(b_in);
      S_RD_LO: bkt_raddr = BAW'(b_q) + BAW'(1);
      default: bkt_raddr = BAW'(b_q);
    endcase
  end

  bstl_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({key_in, in_data_i.text_position}),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  bstl_ram #(
    .WIDTH (CW),
    .DEPTH (NBE)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (fill_q),
    .wdata_i (fill_val_q),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  bstl_step #(
    .CW (CW),
    .KW (KW)
  ) u_step (
    .l_i     (l_q),
    .r_i     (r_q),
    .count_i (count_q),
    .m_i     (m_q),
    .key_i   (key_q),
    .mkey_i  (ent_key),
    .mid_o   (mid),
    .flags_o (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            key_q <= key_in;
            b_q   <= b_in;
            case (in_data_i.action)
              bstl_pkg::ACT_LOAD: begin
                if (load_full) begin
                  pend_q  <= '{status: bstl_pkg::STAT_FULL,
                               entry_index: bstl_pkg::IDX_WIDTH'(count_q),
                               found_text_position: '0};
                  state_q <= S_EMIT;
                end else if (load_order) begin
                  pend_q  <= '{status: bstl_pkg::STAT_ORDER,
                               entry_index: bstl_pkg::IDX_WIDTH'(count_q),
                               found_text_position: '0};
                  state_q <= S_EMIT;
                end else begin
                  pend_q     <= '{status: bstl_pkg::STAT_OK,
                                  entry_index: bstl_pkg::IDX_WIDTH'(count_q),
                                  found_text_position: '0};
                  last_key_q <= key_in;
                  count_q    <= count_q + CW'(1);
                  top_q      <= b_in;
                  fill_q     <= fill_start;
                  fill_val_q <= count_q;
                  if (fill_start <= BAW'(b_in)) begin
                    state_q <= S_FILL;
                  end else begin
                    state_q <= S_EMIT;
                  end
                end
              end
              bstl_pkg::ACT_QUERY: begin
                pend_q <= '{status: bstl_pkg::STAT_NOT_FOUND, entry_index: '0,
                            found_text_position: '0};
                if (count_q != '0 && b_in <= top_q) begin
                  state_q <= S_RD_LO;
                end else begin
                  state_q <= S_EMIT;
                end
              end
              bstl_pkg::ACT_CLEAR: begin
                pend_q  <= '{status: bstl_pkg::STAT_OK, entry_index: '0,
                             found_text_position: '0};
                count_q <= '0;
                top_q   <= '0;
                state_q <= S_EMIT;
              end
              default: begin
                pend_q  <= '{status: bstl_pkg::STAT_NOT_FOUND, entry_index: '0,
                             found_text_position: '0};
                state_q <= S_EMIT;
              end
            endcase
          end
        end
        S_FILL: begin
          fill_q <= fill_q + BAW'(1);
          if (fill_q == BAW'(b_q)) begin
            state_q <= S_EMIT;
          end
        end
        S_RD_LO: begin
          l_q <= bkt_rdata;
          if (b_q == top_q) begin
            r_q     <= count_q - CW'(1);
            state_q <= S_PROBE;
          end else begin
            state_q <= S_RD_HI;
          end
        end
        S_RD_HI: begin
          if (bkt_rdata <= l_q) begin
            state_q <= S_EMIT;
          end else begin
            r_q     <= bkt_rdata - CW'(1);
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          m_q <= mid;
          if (step.go) begin
            state_q <= S_CMP;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_CMP: begin
          if (step.lt) begin
            if (step.m_zero) begin
              state_q <= S_EMIT;
            end else begin
              r_q     <= m_q - CW'(1);
              state_q <= S_PROBE;
            end
          end else if (step.gt) begin
            l_q     <= m_q + CW'(1);
            state_q <= S_PROBE;
          end else begin
            pend_q <= '{status: bstl_pkg::STAT_OK,
                        entry_index: bstl_pkg::IDX_WIDTH'(m_q),
                        found_text_position: ent_pos};
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block still ready after taking a beat");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_probe_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> m_q < count_q)
    else $error("search probe beyond loaded entries");

  a_top_needs_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q != '0 |-> count_q != '0)
    else $error("top bucket set on empty table");

endmodule

### src/bstl_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bstl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/bstl_step.sv
// Shared binary search step unit: range check, midpoint and key compare.
module bstl_step #(
  parameter int unsigned CW = 17,
  parameter int unsigned KW = 32
) (
  input  logic [CW-1:0]  l_i,
  input  logic [CW-1:0]  r_i,
  input  logic [CW-1:0]  count_i,
  input  logic [CW-1:0]  m_i,
  input  logic [KW-1:0]  key_i,
  input  logic [KW-1:0]  mkey_i,
  output logic [CW-1:0]  mid_o,
  output bstl_pkg::step_t flags_o
);

  logic [CW-1:0] span;

  assign span           = r_i - l_i;
  assign mid_o          = l_i + (span >> 1);
  assign flags_o.go     = (l_i <= r_i) && (r_i < count_i);
  assign flags_o.lt     = key_i < mkey_i;
  assign flags_o.gt     = key_i > mkey_i;
  assign flags_o.m_zero = (m_i == '0);

endmodule

### dv/tb_bucketed_sorted_table_lookup.sv
// Testbench for the bucketed sorted table lookup: directed rows, random traffic and a dense fill.
`timescale 1ns / 1ps

module tb_bucketed_sorted_table_lookup;

  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam int unsigned BKT_BITS   = 12;
  localparam int unsigned NUM_BKT    = 1 << BKT_BITS;
  localparam int unsigned TBL_DEPTH  = 65536;
  localparam int unsigned KEY_SHIFT  = bstl_pkg::IN_KEY_WIDTH - BKT_BITS;
  localparam int unsigned RAND_ITEMS = 600;
  localparam int unsigned FILL_ITEMS = 240;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct {
    bstl_pkg::in_t  beat;
    bit             typed;
    bstl_pkg::out_t res;
  } row_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  bstl_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready = 1'b0;
  bstl_pkg::out_t out_data;

  logic [bstl_pkg::IN_KEY_WIDTH-1:0] tbl_key [TBL_DEPTH];
  logic [bstl_pkg::POS_WIDTH-1:0]    tbl_pos [TBL_DEPTH];
  int unsigned                       bkt_first [NUM_BKT + 1];
  int unsigned                       tbl_count;
  int unsigned                       tbl_top_bkt;

  bstl_pkg::out_t lookup_q [$];
  int unsigned    err_cnt  = 0;
  int unsigned    idle_cyc = 0;
  int unsigned    burst_left;
  int unsigned    rdy_left = 0;
  int unsigned    rdy_mode = 0;

  bucketed_sorted_table_lookup i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic row_t dir_row(logic [1:0] act, logic [31:0] key, logic [31:0] pos,
                                   bit typed, logic [1:0] st, logic [15:0] idx,
                                   logic [31:0] tp);
    row_t r;
    r.beat  = '{action: act, key: key, text_position: pos};
    r.typed = typed;
    r.res   = '{status: st, entry_index: idx, found_text_position: tp};
    return r;
  endfunction

  function automatic int unsigned bucket_of(logic [bstl_pkg::IN_KEY_WIDTH-1:0] key);
    return int'(key >> KEY_SHIFT) & (NUM_BKT - 1);
  endfunction

  function automatic bstl_pkg::out_t predict_lookup(bstl_pkg::in_t beat);
    bstl_pkg::out_t r;
    int unsigned    b;
    int             lo;
    int             hi;
    int             mid;
    int             nx;
    bit             done;
    r    = '{status: bstl_pkg::STAT_NOT_FOUND, entry_index: '0, found_text_position: '0};
    b    = bucket_of(beat.key);
    done = 1'b0;
    case (beat.action)
      bstl_pkg::ACT_LOAD: begin
        if (tbl_count >= TBL_DEPTH) begin
          r.status      = bstl_pkg::STAT_FULL;
          r.entry_index = tbl_count[15:0];
        end else if (tbl_count > 0 && beat.key < tbl_key[tbl_count-1]) begin
          r.status      = bstl_pkg::STAT_ORDER;
          r.entry_index = tbl_count[15:0];
        end else begin
          tbl_key[tbl_count] = beat.key;
          tbl_pos[tbl_count] = beat.text_position;
          if (tbl_count == 0) begin
            for (int j = 0; j <= int'(b); j++) bkt_first[j] = 0;
          end else begin
            for (int j = tbl_top_bkt + 1; j <= int'(b); j++) bkt_first[j] = tbl_count;
          end
          tbl_top_bkt   = b;
          r.status      = bstl_pkg::STAT_OK;
          r.entry_index = tbl_count[15:0];
          tbl_count     = tbl_count + 1;
        end
      end
      bstl_pkg::ACT_QUERY: begin
        if (tbl_count != 0 && b <= tbl_top_bkt) begin
          lo = bkt_first[b];
          if (b == tbl_top_bkt) begin
            hi = tbl_count - 1;
          end else begin
            nx = bkt_first[b+1];
            if (nx <= lo) done = 1'b1;
            hi = nx - 1;
          end
          while (!done && lo <= hi && hi < int'(tbl_count)) begin
            mid = lo + (hi - lo) / 2;
            if (beat.key < tbl_key[mid]) begin
              if (mid == 0) done = 1'b1;
              hi = mid - 1;
            end else if (beat.key > tbl_key[mid]) begin
              lo = mid + 1;
            end else begin
              r    = '{status: bstl_pkg::STAT_OK, entry_index: mid[15:0],
                       found_text_position: tbl_pos[mid]};
              done = 1'b1;
            end
          end
        end
      end
      bstl_pkg::ACT_CLEAR: begin
        tbl_count   = 0;
        tbl_top_bkt = 0;
        r.status    = bstl_pkg::STAT_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_beat(bstl_pkg::in_t beat, bit typed, bstl_pkg::out_t typed_res);
    bstl_pkg::out_t pred;
    int unsigned    gap;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_lookup(beat);
    lookup_q.push_back(typed ? typed_res : pred);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(8, 64);
    end
    rdy_left--;
    case (rdy_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (rdy_left[1:0] != 2'd0);
    endcase
  end

  always @(posedge clk) begin
    bstl_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lookup_q.size() == 0) begin
        $display("%0t: unexpected result beat status %0d index %0d position %h", $time,
                 out_data.status, out_data.entry_index, out_data.found_text_position);
        err_cnt++;
      end else begin
        want = lookup_q.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          err_cnt++;
        end
        if (out_data.entry_index !== want.entry_index) begin
          $display("%0t: entry_index expected %0d actual %0d", $time, want.entry_index,
                   out_data.entry_index);
          err_cnt++;
        end
        if (out_data.found_text_position !== want.found_text_position) begin
          $display("%0t: found_text_position expected %h actual %h", $time,
                   want.found_text_position, out_data.found_text_position);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("bucketed_sorted_table_lookup: mismatch");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    row_t           rows [$];
    bstl_pkg::in_t  beat;
    bstl_pkg::out_t none;
    logic [32:0]    nxt;
    logic [31:0]    last;
    logic [31:0]    fill_key;
    int unsigned    sel;
    int unsigned    sub;
    in_valid    = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;
    burst_left  = 1;
    tbl_count   = 0;
    tbl_top_bkt = 0;
    none        = '0;

    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'h0000_0000, 32'h0, 1,
                           bstl_pkg::STAT_NOT_FOUND, 16'd0, 32'h0));
    rows.push_back(dir_row(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                           bstl_pkg::STAT_NOT_FOUND, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_CLEAR, 32'h0000_0000, 32'h0, 1,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_LOAD, 32'h0000_0000, 32'hFFFF_FFFF, 1,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_LOAD, 32'h0010_0005, 32'h1234_5678, 1,
                           bstl_pkg::STAT_OK, 16'd1, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'h4000_0000, 32'h0, 1,
                           bstl_pkg::STAT_NOT_FOUND, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_LOAD, 32'h0010_0005, 32'hA5A5_A5A5, 1,
                           bstl_pkg::STAT_OK, 16'd2, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_LOAD, 32'h0000_0001, 32'hDEAD_BEEF, 1,
                           bstl_pkg::STAT_ORDER, 16'd3, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_LOAD, 32'h8000_0000, 32'h0F0F_0F0F, 1,
                           bstl_pkg::STAT_OK, 16'd3, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 1,
                           bstl_pkg::STAT_OK, 16'd4, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'h0000_0000, 32'h0, 1,
                           bstl_pkg::STAT_OK, 16'd0, 32'hFFFF_FFFF));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'h0010_0005, 32'h0, 0,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'h0020_0000, 32'h0, 1,
                           bstl_pkg::STAT_NOT_FOUND, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'h0, 1,
                           bstl_pkg::STAT_OK, 16'd4, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'hFFFF_FFFE, 32'h0, 0,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'h8000_0000, 32'h0, 0,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'h7FFF_FFFF, 32'h0, 0,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(ACT_UNUSED, 32'h5A5A_5A5A, 32'hC3C3_C3C3, 1,
                           bstl_pkg::STAT_NOT_FOUND, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'h0, 1,
                           bstl_pkg::STAT_NOT_FOUND, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_LOAD, 32'hFFFF_FFFF, 32'h1357_9BDF, 1,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'h0000_0000, 32'h0, 0,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_LOAD, 32'hFFFF_FFFF, 32'h2468_ACE0, 1,
                           bstl_pkg::STAT_OK, 16'd1, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'h0, 0,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));
    rows.push_back(dir_row(bstl_pkg::ACT_CLEAR, 32'h0000_0000, 32'h0, 1,
                           bstl_pkg::STAT_OK, 16'd0, 32'h0));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) push_beat(rows[i].beat, rows[i].typed, rows[i].res);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel  = $urandom_range(0, 99);
      beat = '{action: bstl_pkg::ACT_QUERY, key: $urandom, text_position: $urandom};
      if (sel < 3) begin
        beat.action = bstl_pkg::ACT_CLEAR;
      end else if (sel < 5) begin
        beat.action = ACT_UNUSED;
      end else if (sel < 45) begin
        beat.action = bstl_pkg::ACT_LOAD;
        sub = $urandom_range(0, 99);
        if (tbl_count == 0) begin
          if (sub < 50) beat.key = $urandom_range(0, 32'h0FFF_FFFF);
        end else begin
          last = tbl_key[tbl_count-1];
          if (sub < 8 && last != 0) begin
            beat.key = $urandom_range(0, last - 1);
          end else begin
            sub = $urandom_range(0, 9);
            if (sub < 3)      nxt = {1'b0, last};
            else if (sub < 7) nxt = {1'b0, last} + $urandom_range(1, 15);
            else if (sub < 9) nxt = {1'b0, last} + $urandom_range(1, 32'h0000_FFFF);
            else              nxt = {1'b0, last} + $urandom_range(1, 32'h003F_FFFF);
            beat.key = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
          end
        end
      end else if (tbl_count > 0) begin
        sub  = $urandom_range(0, 9);
        last = tbl_key[$urandom_range(0, tbl_count - 1)];
        if (sub < 5)      beat.key = last;
        else if (sub < 6) beat.key = last + 1;
        else if (sub < 7) beat.key = last - 1;
      end
      push_beat(beat, 1'b0, none);
    end

    // load a dense run of keys in bucket 0 so queries search a long range
    push_beat('{action: bstl_pkg::ACT_CLEAR, key: '0, text_position: '0}, 1'b0, none);
    fill_key = $urandom_range(0, 7);
    for (int n = 0; n < FILL_ITEMS; n++) begin
      push_beat('{action: bstl_pkg::ACT_LOAD, key: fill_key, text_position: $urandom},
                1'b0, none);
      fill_key = fill_key + $urandom_range(0, 1);
    end
    push_beat('{action: bstl_pkg::ACT_LOAD, key: fill_key + 1, text_position: $urandom},
              1'b0, none);
    push_beat('{action: bstl_pkg::ACT_LOAD, key: 32'h0, text_position: $urandom}, 1'b0, none);
    push_beat('{action: bstl_pkg::ACT_LOAD, key: $urandom, text_position: $urandom},
              1'b0, none);
    for (int n = 0; n < 40; n++) begin
      sub = $urandom_range(0, 3);
      if (sub < 2)       beat.key = tbl_key[$urandom_range(0, FILL_ITEMS - 1)];
      else if (sub == 2) beat.key = $urandom_range(0, fill_key + 4);
      else               beat.key = $urandom;
      beat.action        = bstl_pkg::ACT_QUERY;
      beat.text_position = $urandom;
      push_beat(beat, 1'b0, none);
    end
    push_beat('{action: bstl_pkg::ACT_CLEAR, key: '0, text_position: '0}, 1'b0, none);
    push_beat('{action: bstl_pkg::ACT_QUERY, key: tbl_key[0], text_position: '0}, 1'b0, none);

    in_valid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("bucketed_sorted_table_lookup: match");
    end else begin
      $display("bucketed_sorted_table_lookup: mismatch");
    end
    $finish;
  end

endmodule

### bucketed_sorted_table_lookup.f
src/bstl_pkg.sv
src/bstl_ram.sv
src/bstl_step.sv
src/bucketed_sorted_table_lookup.sv
dv/tb_bucketed_sorted_table_lookup.sv
